// ===== hdl/glc_pkg.sv =====
// Shared types, constants and helper functions for the gain level controller.
`timescale 1ns / 1ps

package glc_pkg;

    localparam int GAIN_W      = 4;
    localparam int SAMPLE_W    = 10;
    localparam int KEY_W       = 5;
    localparam int TICKS_W     = 4;
    localparam int REG_IDX_W   = 3;
    localparam int REG_DATA_W  = 10;
    localparam int GAIN_LEVELS = 15;

    typedef logic [GAIN_W-1:0]     t_gain;
    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [KEY_W-1:0]      t_key;
    typedef logic [TICKS_W-1:0]    t_ticks;
    typedef logic [REG_IDX_W-1:0]  t_reg_idx;
    typedef logic [REG_DATA_W-1:0] t_reg_data;

    localparam t_gain  GAIN_MIN   = t_gain'(1);
    localparam t_gain  GAIN_MAX   = t_gain'(GAIN_LEVELS);
    localparam t_ticks TICKS_SAT  = '1;
    localparam t_key   KEY_NONE   = t_key'(0);
    localparam t_key   KEY_DOWN   = t_key'(1);
    localparam t_key   KEY_UP     = t_key'(2);

    localparam t_reg_idx REG_AUTO_EN   = t_reg_idx'(0);
    localparam t_reg_idx REG_IR_EN     = t_reg_idx'(1);
    localparam t_reg_idx REG_HIGH_THR  = t_reg_idx'(2);
    localparam t_reg_idx REG_LOW_THR   = t_reg_idx'(3);
    localparam t_reg_idx REG_IR_SHORT  = t_reg_idx'(4);
    localparam t_reg_idx REG_IR_LONG   = t_reg_idx'(5);

    localparam t_sample HIGH_THR_RST = t_sample'(614);
    localparam t_sample LOW_THR_RST  = t_sample'(164);
    localparam t_ticks  IR_SHORT_RST = t_ticks'(2);
    localparam t_ticks  IR_LONG_RST  = t_ticks'(15);

    typedef enum logic [1:0] {
        IR_IDLE = 2'd0,
        IR_QUAL = 2'd1,
        IR_LONG = 2'd2
    } t_ir_phase;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_ir_event;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_APPLY = 2'd2,
        ST_OUT   = 2'd3
    } t_glc_state;

    typedef enum logic [1:0] {
        W_IDLE  = 2'd0,
        W_SCAN  = 2'd1,
        W_DRAIN = 2'd2
    } t_win_state;

    typedef struct packed {
        logic    start;
        logic    push;
        t_sample sample;
    } t_win_req;

    typedef struct packed {
        logic    done;
        t_sample peak;
    } t_win_stat;

    function automatic t_gain gain_up(input t_gain g);
        return (g >= GAIN_MAX) ? GAIN_MIN : g + t_gain'(1);
    endfunction

    function automatic t_gain gain_down(input t_gain g);
        return (g <= GAIN_MIN) ? GAIN_MAX : g - t_gain'(1);
    endfunction

    function automatic t_ticks ticks_up(input t_ticks t);
        return (t == TICKS_SAT) ? TICKS_SAT : t + t_ticks'(1);
    endfunction

endpackage

// ===== hdl/glc_if.sv =====
// Handshake channels of the gain level controller: tick input, result output, register writes.
`timescale 1ns / 1ps

interface glc_in_if;
    import glc_pkg::*;
    logic    valid;
    logic    ready;
    t_sample adc_sample;
    logic    ir_line;
    t_key    key_id;
    modport source (output valid, output adc_sample, output ir_line, output key_id,
                    input ready);
    modport sink   (input valid, input adc_sample, input ir_line, input key_id,
                    output ready);
endinterface

interface glc_out_if;
    import glc_pkg::*;
    logic      valid;
    logic      ready;
    t_gain     gain_level;
    logic [1:0] ir_event;
    t_sample   peak_sample;
    modport source (output valid, output gain_level, output ir_event, output peak_sample,
                    input ready);
    modport sink   (input valid, input gain_level, input ir_event, input peak_sample,
                    output ready);
endinterface

interface glc_cfg_if;
    import glc_pkg::*;
    logic      valid;
    logic      ready;
    t_reg_idx  reg_index;
    t_reg_data reg_data;
    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== hdl/glc_peak_window.sv =====
// Sample window memory with a one-entry-per-cycle peak scan.
`timescale 1ns / 1ps

module glc_peak_window #(
    parameter int WINDOW_LEN = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glc_pkg::t_win_req  i_req,
    output glc_pkg::t_win_stat o_stat
);
    import glc_pkg::*;

    localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CW = $clog2(WINDOW_LEN + 1);

    t_sample        r_mem [WINDOW_LEN];
    t_win_state     r_state, n_state;
    logic [AW-1:0]  r_wp, n_wp;
    logic [CW-1:0]  r_fill, n_fill;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_pend, n_pend;
    logic           r_keep, n_keep;
    t_sample        r_peak, n_peak;
    t_sample        r_rd_data;
    t_sample        best;
    logic           wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_keep  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_keep  <= n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_peak <= n_peak;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_req.sample;
        end
        r_rd_data <= r_mem[r_cnt[AW-1:0]];
    end

    always_comb begin
        best    = (r_pend && r_keep && (r_rd_data > r_peak)) ? r_rd_data : r_peak;
        n_state = r_state;
        n_wp    = r_wp;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_pend  = 1'b0;
        n_keep  = 1'b0;
        n_peak  = r_peak;
        wr_en   = 1'b0;
        o_stat.done = 1'b0;
        o_stat.peak = best;
        unique case (r_state)
            W_IDLE: begin
                if (i_req.start) begin
                    n_cnt   = '0;
                    n_peak  = '0;
                    n_state = W_SCAN;
                    if (i_req.push) begin
                        wr_en = 1'b1;
                        n_wp  = (r_wp == AW'(WINDOW_LEN - 1)) ? '0 : r_wp + AW'(1);
                        if (r_fill != CW'(WINDOW_LEN)) begin
                            n_fill = r_fill + CW'(1);
                        end
                    end
                end
            end
            W_SCAN: begin
                n_peak = best;
                n_pend = 1'b1;
                n_keep = (r_cnt < r_fill);
                if (r_cnt == CW'(WINDOW_LEN - 1)) begin
                    n_cnt   = '0;
                    n_state = W_DRAIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            W_DRAIN: begin
                n_peak      = best;
                o_stat.done = 1'b1;
                n_state     = W_IDLE;
            end
            default: begin
                n_state = W_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/gain_level_controller_core.sv =====
// Top level of the gain level controller: registers, tick sequencer and gain update.
`timescale 1ns / 1ps

// One tick is taken when i_in.ready is high, which holds whenever no tick is in work.
// A tick passes through these steps in order: the sample is pushed into the window memory
// while automatic gain is enabled, the peak scan reads one window entry per cycle
// through the memory's single read port, the last read is drained, the gain, infrared
// classifier and key state are updated, and the result register is loaded. The
// result register frees the input side, so a new tick may be accepted while a result
// still waits; the tick then stalls only at its final load. Register writes are always
// accepted and should be made between ticks.
module gain_level_controller_core #(
    parameter int WINDOW_LEN = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    glc_in_if.sink      i_in,
    glc_out_if.source   o_out,
    glc_cfg_if.sink     i_cfg
);
    import glc_pkg::*;

    t_glc_state r_state, n_state;

    logic      r_auto_en, r_ir_en;
    t_sample   r_high_thr, r_low_thr;
    t_ticks    r_ir_short, r_ir_long;

    t_gain     r_gain, n_gain;
    t_ir_phase r_phase, n_phase;
    t_ticks    r_ticks, n_ticks;
    logic      r_key_held, n_key_held;
    t_ir_event r_event, n_event;

    logic      r_line;
    t_key      r_key;
    t_sample   r_peak, n_peak;

    logic      r_out_valid, n_out_valid;
    t_gain     r_out_gain;
    t_ir_event r_out_event;
    t_sample   r_out_peak;
    logic      load_out;

    t_win_req  win_req;
    t_win_stat win_stat;

    logic      accept;
    logic      pressed;
    t_ticks    tick_inc;

    glc_peak_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (win_req),
        .o_stat  (win_stat)
    );

    assign i_cfg.ready       = 1'b1;
    assign i_in.ready        = (r_state == ST_IDLE);
    assign accept            = i_in.valid && i_in.ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.gain_level  = r_out_gain;
    assign o_out.ir_event    = r_out_event;
    assign o_out.peak_sample = r_out_peak;

    assign win_req.start  = accept;
    assign win_req.push   = r_auto_en;
    assign win_req.sample = i_in.adc_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_en  <= 1'b0;
            r_ir_en    <= 1'b0;
            r_high_thr <= HIGH_THR_RST;
            r_low_thr  <= LOW_THR_RST;
            r_ir_short <= IR_SHORT_RST;
            r_ir_long  <= IR_LONG_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.reg_index)
                REG_AUTO_EN:  r_auto_en  <= i_cfg.reg_data[0];
                REG_IR_EN:    r_ir_en    <= i_cfg.reg_data[0];
                REG_HIGH_THR: r_high_thr <= i_cfg.reg_data[SAMPLE_W-1:0];
                REG_LOW_THR:  r_low_thr  <= i_cfg.reg_data[SAMPLE_W-1:0];
                REG_IR_SHORT: r_ir_short <= i_cfg.reg_data[TICKS_W-1:0];
                REG_IR_LONG:  r_ir_long  <= i_cfg.reg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain      <= GAIN_MIN;
            r_phase     <= IR_IDLE;
            r_ticks     <= '0;
            r_key_held  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gain      <= n_gain;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_key_held  <= n_key_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line <= i_in.ir_line;
            r_key  <= i_in.key_id;
        end
        r_peak  <= n_peak;
        r_event <= n_event;
        if (load_out) begin
            r_out_gain  <= r_gain;
            r_out_event <= r_event;
            r_out_peak  <= r_peak;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_gain      = r_gain;
        n_phase     = r_phase;
        n_ticks     = r_ticks;
        n_key_held  = r_key_held;
        n_event     = r_event;
        n_peak      = r_peak;
        n_out_valid = r_out_valid && !o_out.ready;
        load_out    = 1'b0;
        pressed     = !r_key_held && (r_key != KEY_NONE);
        tick_inc    = ticks_up(r_ticks);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (win_stat.done) begin
                    n_peak  = win_stat.peak;
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_event    = EV_NONE;
                n_key_held = (r_key != KEY_NONE);
                if (r_auto_en) begin
                    if ((r_peak > r_high_thr) && (n_gain > GAIN_MIN)) begin
                        n_gain = n_gain - t_gain'(1);
                    end
                    if ((r_peak < r_low_thr) && (n_gain < GAIN_MAX)) begin
                        n_gain = n_gain + t_gain'(1);
                    end
                end
                if (r_ir_en) begin
                    unique case (r_phase)
                        IR_IDLE: begin
                            if (r_line) begin
                                n_ticks = tick_inc;
                                if (tick_inc >= r_ir_short) begin
                                    n_phase = IR_QUAL;
                                end
                            end else begin
                                n_ticks = '0;
                            end
                        end
                        IR_QUAL: begin
                            if (r_line) begin
                                n_ticks = tick_inc;
                                if (tick_inc >= r_ir_long) begin
                                    n_phase = IR_LONG;
                                end
                            end else begin
                                n_event = EV_SHORT;
                                n_ticks = '0;
                                n_phase = IR_IDLE;
                            end
                        end
                        IR_LONG: begin
                            if (!r_line) begin
                                n_event = EV_LONG;
                                n_ticks = '0;
                                n_phase = IR_IDLE;
                            end
                        end
                        default: begin
                            n_ticks = '0;
                            n_phase = IR_IDLE;
                        end
                    endcase
                    if (n_event == EV_SHORT) begin
                        n_gain = gain_up(n_gain);
                    end else if (n_event == EV_LONG) begin
                        n_gain = gain_down(n_gain);
                    end
                end
                if (pressed) begin
                    if (r_key == KEY_DOWN) begin
                        n_gain = gain_down(n_gain);
                    end else if (r_key == KEY_UP) begin
                        n_gain = gain_up(n_gain);
                    end
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_gain_level_controller_core.sv =====
// Self-checking regression for gain_level_controller_core: directed and random ticks with idling.
`timescale 1ns / 1ps

module tb_gain_level_controller_core;
    import glc_pkg::*;

    localparam int WINDOW_LEN    = 10;
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_CAP     = 20000;
    localparam int LONG_HOLD     = 80;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 130;
    localparam int RUN_LIMIT_NS  = 4_000_000;

    typedef struct packed {
        t_sample adc;
        logic    ir;
        t_key    key;
    } t_tick;

    typedef struct packed {
        t_gain     gain;
        t_ir_event ev;
        t_sample   peak;
    } t_gain_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    glc_in_if  in_ch ();
    glc_out_if out_ch ();
    glc_cfg_if cfg_ch ();

    gain_level_controller_core #(
        .WINDOW_LEN (WINDOW_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_tick        ticks_to_send [$];
    t_gain_report reports_due [$];
    int           failures = 0;
    bit           quiet = 1'b0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           in_gap = 0;

    // gain controller state as seen from outside
    t_sample   win_q [WINDOW_LEN];
    t_gain     m_gain;
    t_ir_phase m_phase;
    t_ticks    m_ticks;
    bit        m_key_held;
    bit        m_auto_en;
    bit        m_ir_en;
    t_sample   m_high_thr;
    t_sample   m_low_thr;
    t_ticks    m_short;
    t_ticks    m_long;

    function automatic t_gain step_up(input t_gain g);
        return (g >= GAIN_MAX) ? GAIN_MIN : g + 1'b1;
    endfunction

    function automatic t_gain step_down(input t_gain g);
        return (g <= GAIN_MIN) ? GAIN_MAX : g - 1'b1;
    endfunction

    function automatic t_gain_report predict_gain_tick(input t_tick tk);
        t_gain_report r;
        logic         pressed;
        t_sample      pk;
        t_ir_event    ev;
        pressed = !m_key_held && (tk.key != KEY_NONE);
        if (!m_key_held) begin
            if (tk.key != KEY_NONE) m_key_held = 1'b1;
        end else if (tk.key == KEY_NONE) begin
            m_key_held = 1'b0;
        end
        if (m_auto_en) begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) win_q[i] = win_q[i + 1];
            win_q[WINDOW_LEN - 1] = tk.adc;
        end
        pk = '0;
        for (int i = 0; i < WINDOW_LEN; i++) if (win_q[i] > pk) pk = win_q[i];
        if (m_auto_en) begin
            if (pk > m_high_thr && m_gain > GAIN_MIN) m_gain = m_gain - 1'b1;
            if (pk < m_low_thr && m_gain < GAIN_MAX) m_gain = m_gain + 1'b1;
        end
        ev = EV_NONE;
        if (m_ir_en) begin
            case (m_phase)
                IR_IDLE: begin
                    if (tk.ir) begin
                        if (m_ticks != TICKS_SAT) m_ticks = m_ticks + 1'b1;
                        if (m_ticks >= m_short) m_phase = IR_QUAL;
                    end else begin
                        m_ticks = '0;
                    end
                end
                IR_QUAL: begin
                    if (tk.ir) begin
                        if (m_ticks != TICKS_SAT) m_ticks = m_ticks + 1'b1;
                        if (m_ticks >= m_long) m_phase = IR_LONG;
                    end else begin
                        ev = EV_SHORT;
                        m_ticks = '0;
                        m_phase = IR_IDLE;
                    end
                end
                IR_LONG: begin
                    if (!tk.ir) begin
                        ev = EV_LONG;
                        m_ticks = '0;
                        m_phase = IR_IDLE;
                    end
                end
                default: begin
                    m_phase = IR_IDLE;
                    m_ticks = '0;
                end
            endcase
            if (ev == EV_SHORT) m_gain = step_up(m_gain);
            else if (ev == EV_LONG) m_gain = step_down(m_gain);
        end
        if (pressed) begin
            if (tk.key == KEY_DOWN) m_gain = step_down(m_gain);
            else if (tk.key == KEY_UP) m_gain = step_up(m_gain);
        end
        r.gain = m_gain;
        r.ev   = ev;
        r.peak = pk;
        return r;
    endfunction

    // tick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) void'(ticks_to_send.pop_front());
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (ticks_to_send.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    in_gap = $urandom_range(0, 12);
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid      <= 1'b1;
                    in_ch.adc_sample <= ticks_to_send[0].adc;
                    in_ch.ir_line    <= ticks_to_send[0].ir;
                    in_ch.key_id     <= ticks_to_send[0].key;
                end
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor: register writes, accepted ticks and returned reports
    always @(posedge i_clk) begin : monitor
        t_tick        tk;
        t_gain_report want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.reg_index)
                    REG_AUTO_EN:  m_auto_en  = cfg_ch.reg_data[0];
                    REG_IR_EN:    m_ir_en    = cfg_ch.reg_data[0];
                    REG_HIGH_THR: m_high_thr = t_sample'(cfg_ch.reg_data);
                    REG_LOW_THR:  m_low_thr  = t_sample'(cfg_ch.reg_data);
                    REG_IR_SHORT: m_short    = t_ticks'(cfg_ch.reg_data);
                    REG_IR_LONG:  m_long     = t_ticks'(cfg_ch.reg_data);
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                tk.adc = in_ch.adc_sample;
                tk.ir  = in_ch.ir_line;
                tk.key = in_ch.key_id;
                reports_due.push_back(predict_gain_tick(tk));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected report: gain %0d, event %0d, peak %0d", $time,
                             out_ch.gain_level, out_ch.ir_event, out_ch.peak_sample);
                    failures++;
                end else begin
                    want = reports_due.pop_front();
                    if (out_ch.gain_level !== want.gain) begin
                        $display("%0t: gain_level mismatch: expected %0d, actual %0d", $time,
                                 want.gain, out_ch.gain_level);
                        failures++;
                    end
                    if (out_ch.ir_event !== want.ev) begin
                        $display("%0t: ir_event mismatch: expected %0d, actual %0d", $time,
                                 want.ev, out_ch.ir_event);
                        failures++;
                    end
                    if (out_ch.peak_sample !== want.peak) begin
                        $display("%0t: peak_sample mismatch: expected %0d, actual %0d", $time,
                                 want.peak, out_ch.peak_sample);
                        failures++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input int value);
        @(posedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= t_reg_data'(value);
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_settings(input bit auto_on, input bit ir_on, input int hi,
                                  input int lo, input int sh, input int lg);
        write_reg(REG_AUTO_EN, auto_on);
        write_reg(REG_IR_EN, ir_on);
        write_reg(REG_HIGH_THR, hi);
        write_reg(REG_LOW_THR, lo);
        write_reg(REG_IR_SHORT, sh);
        write_reg(REG_IR_LONG, lg);
    endtask

    task automatic queue_tick(input int adc, input bit ir, input int key);
        t_tick tk;
        tk.adc = t_sample'(adc);
        tk.ir  = ir;
        tk.key = t_key'(key);
        ticks_to_send.push_back(tk);
    endtask

    // pulses of random length on the infrared line, key presses held for a few ticks
    task automatic queue_random_ticks(input int n);
        int    count;
        int    hi_run;
        int    lo_run;
        int    key_run;
        int    mode;
        int    adc;
        bit    ir;
        t_key  key;
        count   = 0;
        key_run = 0;
        key     = KEY_NONE;
        while (count < n) begin
            hi_run = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 18);
            lo_run = $urandom_range(1, 4);
            mode   = $urandom_range(0, 3);
            for (int j = 0; j < hi_run + lo_run && count < n; j++) begin
                if (key_run == 0) begin
                    key_run = $urandom_range(1, 5);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: key = KEY_NONE;
                        4, 5:       key = KEY_DOWN;
                        6, 7:       key = KEY_UP;
                        default:    key = t_key'($urandom_range(0, 31));
                    endcase
                end
                key_run--;
                ir = (j < hi_run);
                if ($urandom_range(0, 19) == 0) ir = !ir;
                case (mode)
                    0:       adc = $urandom_range(0, 1023);
                    1:       adc = $urandom_range(0, 200);
                    2:       adc = $urandom_range(550, 1023);
                    default: adc = ($urandom_range(0, 15) == 0) ? 1023 : $urandom_range(0, 100);
                endcase
                queue_tick(adc, ir, key);
                count++;
            end
        end
    endtask

    task automatic wait_results_settled;
        int guard;
        guard = 0;
        while ((ticks_to_send.size() != 0 || reports_due.size() != 0) && guard < DRAIN_CAP) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        #RUN_LIMIT_NS;
        $display("gain_level_controller_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        bit a_on;
        bit ir_on;
        int hi;
        int lo;
        int sh;
        int lg;
        in_ch.valid      = 1'b0;
        in_ch.adc_sample = '0;
        in_ch.ir_line    = 1'b0;
        in_ch.key_id     = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.reg_data  = '0;
        i_rst_n          = 1'b0;
        foreach (win_q[i]) win_q[i] = '0;
        m_gain     = GAIN_MIN;
        m_phase    = IR_IDLE;
        m_ticks    = '0;
        m_key_held = 1'b0;
        m_auto_en  = 1'b0;
        m_ir_en    = 1'b0;
        m_high_thr = HIGH_THR_RST;
        m_low_thr  = LOW_THR_RST;
        m_short    = IR_SHORT_RST;
        m_long     = IR_LONG_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full peak, short and long pulses, key presses with held and wide codes
        apply_settings(1'b1, 1'b1, 614, 164, 2, 4);
        @(negedge i_clk);
        queue_tick(1023, 1'b0, KEY_NONE);
        queue_tick(0, 1'b1, KEY_NONE);
        queue_tick(0, 1'b1, KEY_UP);
        queue_tick(0, 1'b0, KEY_UP);
        repeat (5) queue_tick(300, 1'b1, KEY_NONE);
        queue_tick(300, 1'b0, KEY_NONE);
        queue_tick(0, 1'b0, KEY_DOWN);
        queue_tick(0, 1'b0, KEY_NONE);
        queue_tick(0, 1'b0, 31);
        queue_tick(0, 1'b0, 16);
        queue_tick(0, 1'b0, KEY_NONE);
        queue_tick(512, 1'b0, KEY_NONE);
        wait_results_settled();

        // frozen window, zero pulse lengths
        apply_settings(1'b0, 1'b1, 614, 164, 0, 0);
        @(negedge i_clk);
        queue_tick(1023, 1'b1, KEY_NONE);
        queue_tick(0, 1'b0, KEY_NONE);
        queue_tick(0, 1'b1, KEY_NONE);
        queue_tick(0, 1'b1, KEY_NONE);
        queue_tick(0, 1'b0, KEY_NONE);
        queue_tick(7, 1'b0, KEY_DOWN);
        wait_results_settled();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            a_on  = 1'b1;
            ir_on = 1'b1;
            hi    = $urandom_range(0, 1023);
            lo    = $urandom_range(0, 1023);
            sh    = $urandom_range(0, 15);
            lg    = $urandom_range(0, 15);
            case (p)
                0: begin hi = 0;    lo = 1023; sh = 1;  lg = 1;  end
                1: begin hi = 1023; lo = 0;    sh = 15; lg = 15; end
                2: begin a_on = 1'b0; sh = 3; lg = 8; end
                3: ir_on = 1'b0;
                4: begin hi = 614;  lo = 164;  sh = 2;  lg = 15; end
                5: sh = 0;
                6: begin
                    hi = $urandom_range(400, 1023);
                    lo = $urandom_range(0, 400);
                    sh = $urandom_range(1, 15);
                    lg = $urandom_range(1, 15);
                end
                default: begin hi = 700; lo = 300; sh = 2; lg = 6; end
            endcase
            apply_settings(a_on, ir_on, hi, lo, sh, lg);
            @(negedge i_clk);
            if (p == 0 || p == 5) hold_requests++;
            if (p == RANDOM_PHASES - 1) quiet = 1'b1;
            queue_random_ticks(PHASE_TICKS);
            wait_results_settled();
        end

        if (reports_due.size() != 0) begin
            $display("%0t: %0d reports never returned", $time, reports_due.size());
            failures++;
        end
        if (failures == 0) begin
            $display("gain_level_controller_core regression: pass");
        end else begin
            $display("gain_level_controller_core regression: fail");
        end
        $finish;
    end

endmodule
